/* hdl/wsfd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types and constants shared by the websocket frame decoder modules.
// ----------------------------------------------------------------------------
package wsfd_pkg;

	localparam int LEN_W  = 64;
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	localparam logic [7:0]  LEN_CODE_EXT16 = 8'd126;
	localparam logic [7:0]  LEN_CODE_EXT64 = 8'd127;
	localparam logic [2:0]  EXT16_LAST_CNT = 3'd1;
	localparam logic [2:0]  EXT64_LAST_CNT = 3'd7;
	localparam logic [2:0]  KEY_LAST_CNT   = 3'd3;
	localparam logic [31:0] MAX_PAYLOAD_RST = 32'h0400_0000;

	localparam int          CFG_AW            = 3;
	localparam logic        REG_EXPECT_MASKED = 1'b0;
	localparam logic        REG_MAX_PAYLOAD   = 1'b1;

	typedef enum logic [2:0] {
		PH_BYTE0,
		PH_BYTE1,
		PH_EXT16,
		PH_EXT64,
		PH_KEY,
		PH_PAYLOAD,
		PH_ERROR
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        fin;
		logic [3:0]  opcode;
		logic [31:0] length;
		logic [7:0]  data;
		logic [7:0]  key;
		logic        last;
	} cmd_t;

	typedef struct packed {
		kind_t       kind;
		logic        fin;
		logic [3:0]  opcode;
		logic [31:0] length;
		logic [7:0]  data;
		logic        last;
	} res_t;

endpackage

`default_nettype wire

/* hdl/wsfd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_front
// Header parser: takes stream bytes, tracks the frame phase, runs the header
// checks and issues one command per result into the queue.
// ----------------------------------------------------------------------------
module wsfd_front
	import wsfd_pkg::*;
#(
	parameter int INDEX_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [7:0]  in_byte,
	input  wire logic        expect_masked,
	input  wire logic [31:0] max_payload,
	output logic             cmd_valid,
	output cmd_t             cmd
);

	localparam logic [LEN_W-1:0] IDX_MAX = {LEN_W{1'b1}} >> (LEN_W - INDEX_WIDTH);

	phase_t                   phase_q, phase_d;
	logic [2:0]               hcount_q, hcount_d;
	logic [LEN_W-1:0]         len_q, len_d;
	logic [31:0]              key_q, key_d;
	logic [INDEX_WIDTH-1:0]   idx_q, idx_d;
	logic                     fin_q, fin_d;
	logic [3:0]               opcode_q, opcode_d;
	logic                     masked_q, masked_d;
	logic                     rsv_q, rsv_d;

	logic                     len_done;
	logic                     hdr_done;
	logic [INDEX_WIDTH-1:0]   idx_next;
	logic [7:0]               key_byte;
	logic [2:0]               ext_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BYTE0;
			hcount_q <= '0;
			len_q    <= '0;
			key_q    <= '0;
			idx_q    <= '0;
			fin_q    <= 1'b0;
			opcode_q <= '0;
			masked_q <= 1'b0;
			rsv_q    <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			hcount_q <= hcount_d;
			len_q    <= len_d;
			key_q    <= key_d;
			idx_q    <= idx_d;
			fin_q    <= fin_d;
			opcode_q <= opcode_d;
			masked_q <= masked_d;
			rsv_q    <= rsv_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		hcount_d  = hcount_q;
		len_d     = len_q;
		key_d     = key_q;
		idx_d     = idx_q;
		fin_d     = fin_q;
		opcode_d  = opcode_q;
		masked_d  = masked_q;
		rsv_d     = rsv_q;
		len_done  = 1'b0;
		hdr_done  = 1'b0;
		idx_next  = idx_q + 1'b1;
		key_byte  = masked_q ? key_q[8'(31 - 8 * int'(idx_q[1:0])) -: 8] : 8'h00;
		ext_last  = (phase_q == PH_EXT16) ? EXT16_LAST_CNT : EXT64_LAST_CNT;
		cmd_valid = 1'b0;
		cmd.kind   = KIND_HEADER;
		cmd.fin    = fin_q;
		cmd.opcode = opcode_q;
		cmd.length = '0;
		cmd.data   = '0;
		cmd.key    = '0;
		cmd.last   = 1'b0;

		if (in_valid) begin
			case (phase_q)
				PH_BYTE0: begin
					fin_d    = in_byte[7];
					rsv_d    = |in_byte[6:4];
					opcode_d = in_byte[3:0];
					phase_d  = PH_BYTE1;
				end
				PH_BYTE1: begin
					masked_d = in_byte[7];
					hcount_d = '0;
					len_d    = '0;
					if ({1'b0, in_byte[6:0]} == LEN_CODE_EXT16) begin
						phase_d = PH_EXT16;
					end else if ({1'b0, in_byte[6:0]} == LEN_CODE_EXT64) begin
						phase_d = PH_EXT64;
					end else begin
						len_d    = LEN_W'(in_byte[6:0]);
						len_done = 1'b1;
					end
				end
				PH_EXT16, PH_EXT64: begin
					len_d = {len_q[LEN_W-9:0], in_byte};
					if (hcount_q == ext_last) begin
						len_done = 1'b1;
					end else begin
						hcount_d = hcount_q + 3'd1;
					end
				end
				PH_KEY: begin
					key_d = {key_q[23:0], in_byte};
					if (hcount_q == KEY_LAST_CNT) begin
						hdr_done = 1'b1;
					end else begin
						hcount_d = hcount_q + 3'd1;
					end
				end
				PH_PAYLOAD: begin
					idx_d      = idx_next;
					cmd_valid  = 1'b1;
					cmd.kind   = KIND_PAYLOAD;
					cmd.length = len_q[31:0];
					cmd.data   = in_byte;
					cmd.key    = key_byte;
					if (LEN_W'(idx_next) >= len_q) begin
						cmd.last = 1'b1;
						phase_d  = PH_BYTE0;
					end
				end
				PH_ERROR: begin
					phase_d = PH_ERROR;
				end
				default: begin
					phase_d = PH_ERROR;
				end
			endcase

			if (len_done) begin
				if (rsv_q || (masked_d != expect_masked) ||
				    (len_d > LEN_W'(max_payload)) || (len_d > IDX_MAX)) begin
					phase_d    = PH_ERROR;
					cmd_valid  = 1'b1;
					cmd.kind   = KIND_ERROR;
					cmd.last   = 1'b1;
				end else if (masked_d) begin
					phase_d  = PH_KEY;
					hcount_d = '0;
					key_d    = '0;
				end else begin
					hdr_done = 1'b1;
				end
			end

			if (hdr_done) begin
				idx_d      = '0;
				cmd_valid  = 1'b1;
				cmd.kind   = KIND_HEADER;
				cmd.length = len_d[31:0];
				if (len_d == '0) begin
					phase_d  = PH_BYTE0;
					cmd.last = 1'b1;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/wsfd_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_queue
// Short command queue between the header parser and the result stage.
// ----------------------------------------------------------------------------
module wsfd_queue
	import wsfd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_cmd,
	input  wire logic pop,
	output logic      full,
	output logic      not_empty,
	output cmd_t      head
);

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full      = (count_q == (QAW + 1)'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/wsfd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_back
// Result stage: unmasks payload bytes and holds the oldest result item
// until it is popped.
// ----------------------------------------------------------------------------
module wsfd_back
	import wsfd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_avail,
	input  cmd_t      cmd,
	output logic      cmd_take,
	input  wire logic pop,
	output logic      empty,
	output res_t      res
);

	logic out_valid_q;
	res_t out_q;

	assign cmd_take = cmd_avail && (!out_valid_q || pop);
	assign empty    = !out_valid_q;
	assign res      = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_take) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			out_q.kind   <= cmd.kind;
			out_q.fin    <= cmd.fin;
			out_q.opcode <= cmd.opcode;
			out_q.length <= cmd.length;
			out_q.data   <= cmd.data ^ cmd.key;
			out_q.last   <= cmd.last;
		end
	end

endmodule

`default_nettype wire

/* hdl/websocket_frame_decoder_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_decoder_core
// Receive-side websocket frame decoder with queue-style item ports.
// ----------------------------------------------------------------------------
// One stream byte is taken per clock cycle while full is low; the header parser
// updates its phase state once per byte. A header, payload or error result is
// decoded by the parser combinationally, then registered in the four-entry
// command queue and in the output register before it reaches the result ports.
// full rises only when the command queue is full, i.e. when results are not being
// popped. After a protocol error one error item is given and all further bytes
// are dropped until reset. Configuration registers: expect_masked at address 0
// and max_payload at address 4; write them only while the block is idle.
// ----------------------------------------------------------------------------
module websocket_frame_decoder_core
	import wsfd_pkg::*;
#(
	parameter int INDEX_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [7:0]        stream_byte,
	output logic                   empty,
	input  wire logic              pop,
	output logic [1:0]             kind,
	output logic                   fin,
	output logic [3:0]             opcode,
	output logic [31:0]            payload_length,
	output logic [7:0]             payload_byte,
	output logic                   last,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	logic        expect_masked_q;
	logic [31:0] max_payload_q;
	logic        cfg_wr;

	logic        in_valid;
	logic        cmd_valid;
	cmd_t        cmd;
	logic        q_not_empty;
	cmd_t        q_head;
	logic        cmd_take;
	res_t        res;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_masked_q <= 1'b0;
			max_payload_q   <= MAX_PAYLOAD_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_EXPECT_MASKED: expect_masked_q <= pwdata[0];
				REG_MAX_PAYLOAD:   max_payload_q   <= pwdata;
				default:           max_payload_q   <= max_payload_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_EXPECT_MASKED: prdata = {31'd0, expect_masked_q};
			REG_MAX_PAYLOAD:   prdata = max_payload_q;
			default:           prdata = '0;
		endcase
	end

	assign in_valid = push && !full;

	wsfd_front #(
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_byte       (stream_byte),
		.expect_masked (expect_masked_q),
		.max_payload   (max_payload_q),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd)
	);

	wsfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_valid),
		.push_cmd  (cmd),
		.pop       (cmd_take),
		.full      (full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	wsfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (q_not_empty),
		.cmd       (q_head),
		.cmd_take  (cmd_take),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign kind           = res.kind;
	assign fin            = res.fin;
	assign opcode         = res.opcode;
	assign payload_length = res.length;
	assign payload_byte   = res.data;
	assign last           = res.last;

endmodule

`default_nettype wire
